// ===== rtl/m3i_pkg.sv =====
// m3i_pkg: shared widths, constants and reset values for the 3x3 inverse unit
// no dependencies; imported by every module of the block

package m3i_pkg;

   // matrix geometry and element format
   localparam int N_ELEM        = 9;
   localparam int N_DIAG_STEP   = 4;   // diagonal elements sit every fourth place
   localparam int ELEM_W        = 32;
   localparam int FRAC_BITS_DEF = 16;

   // exact intermediate widths: cofactors fit 64 bits signed, |det| < 2^96
   localparam int COF_W         = 64;
   localparam int DET_W         = 98;
   localparam int DMAG_W        = 97;
   localparam int PLO_W         = 2 * ELEM_W + 1;

   // quotient: 32 result bits plus one overflow probe stage
   localparam int Q_BITS        = 32;
   localparam int DIV_STAGES    = Q_BITS + 1;
   localparam int CMP_W         = DMAG_W + Q_BITS + 1;

   // front pipeline depth and queue depth
   localparam int FRONT_STAGES  = 5;
   localparam int QUEUE_DEPTH   = 2;

   // threshold register
   localparam int               THRESH_W     = 32;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd282;

   // saturation limits on the quotient magnitude
   localparam logic [Q_BITS-1:0] MAG_NEG_LIM = 32'h8000_0000;
   localparam logic [Q_BITS-1:0] MAG_POS_LIM = 32'h7FFF_FFFF;

endpackage

// ===== rtl/m3i_front.sv =====
// m3i_front: cofactor and determinant pipeline, singular classification
// and the threshold register; depends on m3i_pkg

module m3i_front
   import m3i_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int NUM_W = COF_W + 2 * FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [THRESH_W-1:0]              csr_wdata,
   input  logic                             in_valid,
   output logic                             in_stall,
   input  logic [N_ELEM-1:0][ELEM_W-1:0]    in_elem,
   output logic                             out_valid,
   input  logic                             out_full,
   output logic [N_ELEM-1:0][NUM_W-1:0]     out_num,
   output logic [N_ELEM-1:0]                out_neg,
   output logic [DMAG_W-1:0]                out_dmag,
   output logic                             out_singular
);

   // cofactor operand places: c = m[a]*m[b] - m[c]*m[d]
   localparam int CIDX [N_ELEM][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   logic                        adv;
   logic [FRONT_STAGES-1:0]     vld_ff, vld_in;
   logic [THRESH_W-1:0]         thr_ff;

   logic signed [ELEM_W-1:0]    el [N_ELEM];
   logic signed [COF_W-1:0]     prod_ff [2*N_ELEM], prod_in [2*N_ELEM];
   logic signed [ELEM_W-1:0]    el1_ff [3], el2_ff [3];
   logic signed [COF_W-1:0]     cof2_ff [N_ELEM], cof2_in [N_ELEM];
   logic signed [COF_W-1:0]     cof3_ff [N_ELEM], cof4_ff [N_ELEM];
   logic signed [COF_W-1:0]     phi_ff [3], phi_in [3];
   logic signed [PLO_W-1:0]     plo_ff [3], plo_in [3];
   logic signed [DET_W-1:0]     det_ff, det_in;
   logic [NUM_W-1:0]            num_ff [N_ELEM], num_in [N_ELEM];
   logic [N_ELEM-1:0]           neg_ff, neg_in;
   logic [DMAG_W-1:0]           dmag_ff, dmag_in;
   logic                        sing_ff, sing_in;

   assign adv      = !vld_ff[FRONT_STAGES-1] || !out_full;
   assign in_stall = !adv;
   assign vld_in   = {vld_ff[FRONT_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= THRESH_RESET;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         if (csr_wen) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   // stage 1: eighteen element products
   for (genvar i = 0; i < N_ELEM; i++) begin : g_prod
      assign el[i] = $signed(in_elem[i]);
      assign prod_in[2*i]   = el[CIDX[i][0]] * el[CIDX[i][1]];
      assign prod_in[2*i+1] = el[CIDX[i][2]] * el[CIDX[i][3]];
      // stage 2: cofactor differences, no overflow at 64 bits
      assign cof2_in[i] = prod_ff[2*i] - prod_ff[2*i+1];
   end

   // stage 3: first row times first adjugate column, split into 32-bit halves
   for (genvar k = 0; k < 3; k++) begin : g_det
      logic signed [ELEM_W:0] lo_op;
      assign lo_op     = $signed({1'b0, cof2_ff[3*k][ELEM_W-1:0]});
      assign phi_in[k] = $signed(cof2_ff[3*k][COF_W-1:ELEM_W]) * el2_ff[k];
      assign plo_in[k] = lo_op * el2_ff[k];
   end

   // stage 4: exact determinant
   assign det_in = (DET_W'(phi_ff[0]) <<< ELEM_W) + DET_W'(plo_ff[0])
                 + (DET_W'(phi_ff[1]) <<< ELEM_W) + DET_W'(plo_ff[1])
                 + (DET_W'(phi_ff[2]) <<< ELEM_W) + DET_W'(plo_ff[2]);

   // stage 5: magnitudes, signs, scaled numerators and the singular test
   always_comb begin
      logic [DET_W-1:0] dabs;
      logic [COF_W-1:0] cabs;
      dabs    = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
      dmag_in = dabs[DMAG_W-1:0];
      sing_in = (dmag_in == '0) || (dmag_in < DMAG_W'(thr_ff));
      for (int i = 0; i < N_ELEM; i++) begin
         cabs      = cof4_ff[i][COF_W-1] ? COF_W'(-cof4_ff[i]) : COF_W'(cof4_ff[i]);
         num_in[i] = NUM_W'(cabs) << (2 * FRAC_BITS);
         neg_in[i] = cof4_ff[i][COF_W-1] ^ det_ff[DET_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         el1_ff  <= '{el[0], el[1], el[2]};
         cof2_ff <= cof2_in;
         el2_ff  <= el1_ff;
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         cof3_ff <= cof2_ff;
         det_ff  <= det_in;
         cof4_ff <= cof3_ff;
         num_ff  <= num_in;
         neg_ff  <= neg_in;
         dmag_ff <= dmag_in;
         sing_ff <= sing_in;
      end
   end

   assign out_valid    = vld_ff[FRONT_STAGES-1];
   assign out_neg      = neg_ff;
   assign out_dmag     = dmag_ff;
   assign out_singular = sing_ff;
   for (genvar i = 0; i < N_ELEM; i++) begin : g_out
      assign out_num[i] = num_ff[i];
   end

endmodule

// ===== rtl/m3i_queue.sv =====
// m3i_queue: small register queue between the front and the divider back end
// depends on m3i_pkg for the default depth

module m3i_queue
   import m3i_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] ent_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = ent_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/m3i_back.sv =====
// m3i_back: nine pipelined restoring dividers (an overflow probe stage, then one quotient bit per stage),
// then saturation, identity select and the result register; depends on m3i_pkg

module m3i_back
   import m3i_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int NUM_W = COF_W + 2 * FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_pop,
   input  logic [N_ELEM-1:0][NUM_W-1:0]     in_num,
   input  logic [N_ELEM-1:0]                in_neg,
   input  logic [DMAG_W-1:0]                in_dmag,
   input  logic                             in_singular,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [N_ELEM-1:0][ELEM_W-1:0]    rsp_elem,
   output logic                             rsp_singular,
   output logic                             rsp_saturated
);

   localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

   logic                    adv;
   logic [DIV_STAGES-1:0]   vld_ff, vld_src;

   logic [NUM_W-1:0]        rem_ff [DIV_STAGES][N_ELEM], rem_src [DIV_STAGES][N_ELEM];
   logic [NUM_W-1:0]        rem_in [DIV_STAGES][N_ELEM];
   logic [Q_BITS-1:0]       q_ff [DIV_STAGES][N_ELEM], q_src [DIV_STAGES][N_ELEM];
   logic [Q_BITS-1:0]       q_in [DIV_STAGES][N_ELEM];
   logic [N_ELEM-1:0]       ovf_ff [DIV_STAGES], ovf_src [DIV_STAGES], ovf_in [DIV_STAGES];
   logic [N_ELEM-1:0]       neg_ff [DIV_STAGES], neg_src [DIV_STAGES];
   logic [DMAG_W-1:0]       dmag_ff [DIV_STAGES], dmag_src [DIV_STAGES];
   logic [DIV_STAGES-1:0]   sing_ff, sing_src;

   logic                             out_vld_ff;
   logic [N_ELEM-1:0][ELEM_W-1:0]    out_elem_ff, out_elem_in;
   logic                             out_sing_ff, out_sat_ff, out_sat_in;

   assign adv    = !out_vld_ff || !rsp_stall;
   assign in_pop = adv;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int BIT = Q_BITS - s;

      if (s == 0) begin : g_head
         assign vld_src[s]  = in_valid;
         assign neg_src[s]  = in_neg;
         assign dmag_src[s] = in_dmag;
         assign sing_src[s] = in_singular;
         assign ovf_src[s]  = '0;
         for (genvar e = 0; e < N_ELEM; e++) begin : g_e
            assign rem_src[s][e] = in_num[e];
            assign q_src[s][e]   = '0;
         end
      end else begin : g_body
         assign vld_src[s]  = vld_ff[s-1];
         assign neg_src[s]  = neg_ff[s-1];
         assign dmag_src[s] = dmag_ff[s-1];
         assign sing_src[s] = sing_ff[s-1];
         assign ovf_src[s]  = ovf_ff[s-1];
         for (genvar e = 0; e < N_ELEM; e++) begin : g_e
            assign rem_src[s][e] = rem_ff[s-1][e];
            assign q_src[s][e]   = q_ff[s-1][e];
         end
      end

      // one trial subtraction per element; the top stage only probes overflow
      always_comb begin
         logic [CMP_W-1:0] den_sh;
         logic [CMP_W-1:0] rem_x;
         logic             ge;
         den_sh = CMP_W'(dmag_src[s]) << BIT;
         for (int e = 0; e < N_ELEM; e++) begin
            rem_x         = CMP_W'(rem_src[s][e]);
            ge            = (rem_x >= den_sh);
            rem_in[s][e]  = rem_src[s][e];
            q_in[s][e]    = q_src[s][e];
            ovf_in[s][e]  = ovf_src[s][e];
            if (BIT == Q_BITS) begin
               ovf_in[s][e] = ge;
            end else if (ge) begin
               rem_in[s][e] = NUM_W'(rem_x - den_sh);
               q_in[s][e]   = q_src[s][e] | (Q_BITS'(1) << BIT);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            ovf_ff[s]  <= ovf_in[s];
            neg_ff[s]  <= neg_src[s];
            dmag_ff[s] <= dmag_src[s];
            sing_ff[s] <= sing_src[s];
         end
      end
   end

   // saturation and identity select on the last divider stage
   always_comb begin
      logic [Q_BITS-1:0] qv;
      logic [Q_BITS-1:0] mag;
      logic              sat;
      out_sat_in = 1'b0;
      for (int e = 0; e < N_ELEM; e++) begin
         qv  = q_ff[DIV_STAGES-1][e];
         sat = 1'b0;
         if (neg_ff[DIV_STAGES-1][e]) begin
            if (ovf_ff[DIV_STAGES-1][e] || (qv > MAG_NEG_LIM)) begin
               mag = MAG_NEG_LIM;
               sat = 1'b1;
            end else begin
               mag = qv;
            end
            out_elem_in[e] = ELEM_W'(-mag);
         end else begin
            if (ovf_ff[DIV_STAGES-1][e] || (qv > MAG_POS_LIM)) begin
               mag = MAG_POS_LIM;
               sat = 1'b1;
            end else begin
               mag = qv;
            end
            out_elem_in[e] = ELEM_W'(mag);
         end
         out_sat_in = out_sat_in | sat;
         if (sing_ff[DIV_STAGES-1]) begin
            out_elem_in[e] = ((e % N_DIAG_STEP) == 0) ? ONE : '0;
         end
      end
      if (sing_ff[DIV_STAGES-1]) begin
         out_sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_elem_ff <= out_elem_in;
         out_sing_ff <= sing_ff[DIV_STAGES-1];
         out_sat_ff  <= out_sat_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_elem      = out_elem_ff;
   assign rsp_singular  = out_sing_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

// ===== rtl/matrix3_inverse_unit.sv =====
// matrix3_inverse_unit: top level of the 3x3 fixed-point inverse (adjugate method)
// depends on m3i_pkg, m3i_front, m3i_queue, m3i_back
//
//   channel  ports                        direction  beat
//   req      req_valid/req_stall, a00..   in         one matrix, nine Q elements
//   rsp      rsp_valid/rsp_stall, r00..   out        inverse plus singular/saturated
//   csr      csr_wen, csr_wdata           in         singular threshold write
//
// one beat per cycle sustained while neither side stalls; a beat passes the front
// pipeline, the queue, 33 divider stages (overflow probe plus one quotient bit
// each) and the result register
// reset is synchronous: it empties both pipelines and the queue and loads the
// threshold with 282 (1e-12 at the determinant scale)
// a stall on rsp freezes only the back end; the front keeps filling the queue
// and stalls req only once the queue is full and its last stage holds a beat

module matrix3_inverse_unit
   import m3i_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_wen,
   input  logic [THRESH_W-1:0]  csr_wdata,
   // matrix in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ELEM_W-1:0]    req_a00,
   input  logic [ELEM_W-1:0]    req_a01,
   input  logic [ELEM_W-1:0]    req_a02,
   input  logic [ELEM_W-1:0]    req_a10,
   input  logic [ELEM_W-1:0]    req_a11,
   input  logic [ELEM_W-1:0]    req_a12,
   input  logic [ELEM_W-1:0]    req_a20,
   input  logic [ELEM_W-1:0]    req_a21,
   input  logic [ELEM_W-1:0]    req_a22,
   // inverse out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ELEM_W-1:0]    rsp_r00,
   output logic [ELEM_W-1:0]    rsp_r01,
   output logic [ELEM_W-1:0]    rsp_r02,
   output logic [ELEM_W-1:0]    rsp_r10,
   output logic [ELEM_W-1:0]    rsp_r11,
   output logic [ELEM_W-1:0]    rsp_r12,
   output logic [ELEM_W-1:0]    rsp_r20,
   output logic [ELEM_W-1:0]    rsp_r21,
   output logic [ELEM_W-1:0]    rsp_r22,
   output logic                 rsp_singular,
   output logic                 rsp_saturated
);

   // numerator is |cofactor| scaled up by 2*FRAC_BITS
   localparam int NUM_W = COF_W + 2 * FRAC_BITS;
   // queue word: numerators, signs, |det|, singular flag
   localparam int QW    = N_ELEM * NUM_W + N_ELEM + DMAG_W + 1;

   logic [N_ELEM-1:0][ELEM_W-1:0]  req_elem;
   logic [N_ELEM-1:0][ELEM_W-1:0]  rsp_elem;

   // front to queue
   logic                           f_valid;
   logic [N_ELEM-1:0][NUM_W-1:0]   f_num;
   logic [N_ELEM-1:0]              f_neg;
   logic [DMAG_W-1:0]              f_dmag;
   logic                           f_sing;
   logic                           q_full;

   // queue to back
   logic                           q_avail;
   logic                           q_pop;
   logic [QW-1:0]                  q_wdata, q_rdata;
   logic [N_ELEM-1:0][NUM_W-1:0]   b_num;
   logic [N_ELEM-1:0]              b_neg;
   logic [DMAG_W-1:0]              b_dmag;
   logic                           b_sing;

   assign req_elem = {req_a22, req_a21, req_a20,
                      req_a12, req_a11, req_a10,
                      req_a02, req_a01, req_a00};

   m3i_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_elem      (req_elem),
      .out_valid    (f_valid),
      .out_full     (q_full),
      .out_num      (f_num),
      .out_neg      (f_neg),
      .out_dmag     (f_dmag),
      .out_singular (f_sing)
   );

   assign q_wdata = {f_num, f_neg, f_dmag, f_sing};

   // two-entry queue decouples the front from back-end stalls
   m3i_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_avail),
      .pop_data  (q_rdata)
   );

   assign {b_num, b_neg, b_dmag, b_sing} = q_rdata;

   m3i_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_avail),
      .in_pop        (q_pop),
      .in_num        (b_num),
      .in_neg        (b_neg),
      .in_dmag       (b_dmag),
      .in_singular   (b_sing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_elem      (rsp_elem),
      .rsp_singular  (rsp_singular),
      .rsp_saturated (rsp_saturated)
   );

   assign rsp_r00 = rsp_elem[0];
   assign rsp_r01 = rsp_elem[1];
   assign rsp_r02 = rsp_elem[2];
   assign rsp_r10 = rsp_elem[3];
   assign rsp_r11 = rsp_elem[4];
   assign rsp_r12 = rsp_elem[5];
   assign rsp_r20 = rsp_elem[6];
   assign rsp_r21 = rsp_elem[7];
   assign rsp_r22 = rsp_elem[8];

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for matrix3_inverse_unit, the 3x3 adjugate inverse
// depends on m3i_pkg and the block's rtl; a scoreboard class predicts every inverse
// exactly with wide integer arithmetic and checks each result beat in order

module testbench;
   import m3i_pkg::*;

   typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_type;

   typedef struct packed {
      logic [N_ELEM-1:0][ELEM_W-1:0] elem;
      logic                          singular;
      logic                          saturated;
   } inv_type;

   localparam int IDLE_LIMIT  = 5000;
   localparam int SHOW_LIMIT  = 10;
   localparam int UNITY       = 1 << FRAC_BITS_DEF;

   // expected inverses in arrival order, with the bench's copy of the threshold
   class inverse_scoreboard;
      logic [THRESH_W-1:0] threshold;
      inv_type             pending[$];
      int                  errors;

      function new();
         threshold = THRESH_RESET;
         errors    = 0;
      endfunction

      function inv_type invert_matrix(mat_type m);
         logic signed [127:0] e[N_ELEM];
         logic signed [127:0] c[N_ELEM];
         logic signed [127:0] det;
         logic [127:0]        dmag, num, q;
         logic [Q_BITS-1:0]   mag;
         logic                neg;
         inv_type             r;
         for (int i = 0; i < N_ELEM; i++) e[i] = $signed(m[i]);
         // adjugate, each cofactor exact
         c[0] = e[4] * e[8] - e[5] * e[7];
         c[1] = e[2] * e[7] - e[1] * e[8];
         c[2] = e[1] * e[5] - e[2] * e[4];
         c[3] = e[5] * e[6] - e[3] * e[8];
         c[4] = e[0] * e[8] - e[2] * e[6];
         c[5] = e[2] * e[3] - e[0] * e[5];
         c[6] = e[3] * e[7] - e[4] * e[6];
         c[7] = e[1] * e[6] - e[0] * e[7];
         c[8] = e[0] * e[4] - e[1] * e[3];
         det  = c[0] * e[0] + c[3] * e[1] + c[6] * e[2];
         dmag = (det < 0) ? -det : det;
         r    = '0;
         if (dmag == 0 || dmag < threshold) begin
            // singular: identity comes back
            for (int i = 0; i < N_ELEM; i++)
               r.elem[i] = (i % N_DIAG_STEP == 0) ? ELEM_W'(UNITY) : '0;
            r.singular = 1'b1;
            return r;
         end
         for (int i = 0; i < N_ELEM; i++) begin
            neg = (c[i] < 0) != (det < 0);
            num = ((c[i] < 0) ? -c[i] : c[i]);
            num = num << (2 * FRAC_BITS_DEF);
            q   = num / dmag;
            if (neg) begin
               if (q > MAG_NEG_LIM) begin
                  mag = MAG_NEG_LIM;
                  r.saturated = 1'b1;
               end else begin
                  mag = q[Q_BITS-1:0];
               end
               r.elem[i] = -mag;
            end else begin
               if (q > MAG_POS_LIM) begin
                  mag = MAG_POS_LIM;
                  r.saturated = 1'b1;
               end else begin
                  mag = q[Q_BITS-1:0];
               end
               r.elem[i] = mag;
            end
         end
         return r;
      endfunction

      function void record_matrix(mat_type m);
         pending.push_back(invert_matrix(m));
      endfunction

      function void check_inverse(inv_type got);
         inv_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= SHOW_LIMIT) $display("result beat with nothing outstanding");
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < N_ELEM; i++)
            if (got.elem[i] !== want.elem[i]) begin
               errors++;
               if (errors <= SHOW_LIMIT)
                  $display("r%0d%0d: expected %h, got %h", i / 3, i % 3,
                           want.elem[i], got.elem[i]);
            end
         if (got.singular !== want.singular) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("singular: expected %b, got %b", want.singular, got.singular);
         end
         if (got.saturated !== want.saturated) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("saturated: expected %b, got %b", want.saturated, got.saturated);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wen;
   logic [THRESH_W-1:0] csr_wdata;
   logic                req_valid;
   logic                req_stall;
   mat_type             req_m;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ELEM_W-1:0]   rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12;
   logic [ELEM_W-1:0]   rsp_r20, rsp_r21, rsp_r22;
   logic                rsp_singular, rsp_saturated;
   inv_type             rsp_beat;

   inverse_scoreboard   sb = new();
   int                  idle_cycles;
   int                  burst_left;

   matrix3_inverse_unit dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_a00      (req_m[0]),
      .req_a01      (req_m[1]),
      .req_a02      (req_m[2]),
      .req_a10      (req_m[3]),
      .req_a11      (req_m[4]),
      .req_a12      (req_m[5]),
      .req_a20      (req_m[6]),
      .req_a21      (req_m[7]),
      .req_a22      (req_m[8]),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_r00      (rsp_r00),
      .rsp_r01      (rsp_r01),
      .rsp_r02      (rsp_r02),
      .rsp_r10      (rsp_r10),
      .rsp_r11      (rsp_r11),
      .rsp_r12      (rsp_r12),
      .rsp_r20      (rsp_r20),
      .rsp_r21      (rsp_r21),
      .rsp_r22      (rsp_r22),
      .rsp_singular (rsp_singular),
      .rsp_saturated(rsp_saturated)
   );

   // element 0 sits in the low word, as on the request side
   assign rsp_beat = {rsp_r22, rsp_r21, rsp_r20, rsp_r12, rsp_r11, rsp_r10,
                      rsp_r02, rsp_r01, rsp_r00, rsp_singular, rsp_saturated};

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // beats are sampled at the edge, before this step's drive updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.record_matrix(req_m);
         if (rsp_valid && !rsp_stall) sb.check_inverse(rsp_beat);
      end
   end

   // watchdog: too long with no beat on either side means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side back-pressure: quiet stretches, short flicker and a few long holds
   initial begin : stall_gen
      int left;
      int pick;
      logic hold;
      left = 0;
      hold = 1'b0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               hold = 1'b0;
               left = $urandom_range(30, 120);
            end else if (pick < 70) begin
               hold = 1'b0;
               left = $urandom_range(1, 4);
            end else if (pick < 92) begin
               hold = 1'b1;
               left = $urandom_range(1, 3);
            end else begin
               hold = 1'b1;
               left = $urandom_range(10, 40);
            end
         end
         left--;
         rsp_stall <= hold;
      end
   end

   function automatic logic [ELEM_W-1:0] near_zero();
      return ELEM_W'($urandom_range(0, 65535)) - 32'd32768;
   endfunction

   function automatic mat_type diag_of(logic [ELEM_W-1:0] v);
      mat_type m;
      m = '0;
      for (int i = 0; i < N_ELEM; i += N_DIAG_STEP) m[i] = v;
      return m;
   endfunction

   // random matrix: well-conditioned most often (40 in 100), plus raw noise, tiny, degenerate and edge mixes
   function automatic mat_type make_matrix();
      mat_type m;
      int      style;
      int      pick;
      style = $urandom_range(0, 99);
      for (int i = 0; i < N_ELEM; i++) m[i] = $urandom();
      if (style < 40) begin
         for (int i = 0; i < N_ELEM; i++)
            m[i] = (i % N_DIAG_STEP == 0) ? ELEM_W'(UNITY) + near_zero() : near_zero();
      end else if (style < 55) begin
         for (int i = 0; i < N_ELEM; i++) m[i] = ELEM_W'($urandom_range(0, 32)) - 32'd16;
      end else if (style < 70) begin
         // rank deficient: repeated row or zero column
         if ($urandom_range(0, 1)) begin
            for (int j = 0; j < 3; j++) m[6 + j] = m[j];
         end else begin
            pick = $urandom_range(0, 2);
            for (int j = 0; j < 3; j++) m[3 * j + pick] = '0;
         end
      end else if (style < 85) begin
         for (int i = 0; i < N_ELEM; i++) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0: m[i] = 32'h8000_0000;
               1: m[i] = 32'h7FFF_FFFF;
               2: m[i] = '0;
               3: m[i] = 32'd1;
               4: m[i] = 32'hFFFF_FFFF;
               default: ;
            endcase
         end
      end
      return m;
   endfunction

   task automatic send_matrix(mat_type m);
      int gap;
      int pick;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 10) burst_left = $urandom_range(20, 60);
         else if (pick < 55) gap = 0;
         else if (pick < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_m     <= m;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_matrix(make_matrix());
   endtask

   // sender holds off until every outstanding inverse is back
   // it waits on the clock first so the last accepted beat is already on the scoreboard
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THRESH_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.threshold = v;
   endtask

   initial begin : main
      mat_type m;
      reset      = 1'b1;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      req_valid  = 1'b0;
      req_m      = '0;
      rsp_stall  = 1'b0;
      idle_cycles = 0;
      burst_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, threshold still at its reset value
      send_matrix('0);                          // zero determinant
      send_matrix(diag_of(ELEM_W'(UNITY)));     // identity
      send_matrix(diag_of(-ELEM_W'(UNITY)));    // minus identity
      send_matrix(diag_of(ELEM_W'(2 * UNITY)));
      send_matrix('{default: 32'h7FFF_FFFF});   // all max, rank one
      send_matrix('{default: 32'h8000_0000});   // all min, rank one
      send_matrix(diag_of(32'h8000_0000));
      send_matrix(diag_of(32'h7FFF_FFFF));
      send_matrix(diag_of(32'd7));              // tiny but above threshold: large inverse, no clamp
      send_matrix(diag_of(-32'd7));             // tiny negative, above threshold: no clamp
      send_matrix(diag_of(32'd6));              // just under threshold
      m = '0;
      m[1] = ELEM_W'(UNITY); m[5] = ELEM_W'(UNITY); m[6] = ELEM_W'(UNITY);
      send_matrix(m);                           // permutation
      m = '{default: 32'hAAAA_AAAA};
      m[1] = 32'h5555_5555; m[5] = 32'h5555_5555; m[6] = 32'h5555_5555;
      send_matrix(m);
      m = diag_of(32'h8000_0000);
      m[1] = 32'h7FFF_FFFF; m[2] = 32'h8000_0000; m[5] = 32'h7FFF_FFFF;
      send_matrix(m);                           // triangular with extremes
      m = diag_of(ELEM_W'(UNITY));
      m[3] = 32'h0001_8000; m[7] = 32'hFFFF_4000;
      send_matrix(m);
      drain();

      // threshold zero: only an exact zero determinant is singular
      write_threshold('0);
      send_matrix(diag_of(32'd1));              // inverse 2^32 clamps
      send_matrix(diag_of(32'd2));              // +2^31 clamps
      send_matrix(diag_of(-32'd2));             // exactly -2^31 is kept
      send_random(150);
      drain();

      write_threshold(32'hFFFF_FFFF);
      send_random(150);
      drain();

      write_threshold($urandom());
      send_random(130);
      drain();

      write_threshold(32'd1);
      send_random(120);
      drain();

      write_threshold(THRESH_RESET);
      send_random(120);
      drain();
      repeat (50) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_queue.sv
rtl/m3i_back.sv
rtl/matrix3_inverse_unit.sv
bench/testbench.sv
